### src/pmst_pkg.sv
// Package for the pending message slot table.
// Holds the beat types, result codes, controller states and shared constants.
// No dependencies; every other file of the block imports it.
`default_nettype none

package pmst_pkg;

  // Default table depth and the cap on results from one release command
  localparam int unsigned SLOT_COUNT_DEF = 16;
  localparam int unsigned MAX_RESULTS    = 16;
  localparam int unsigned CNT_W          = $clog2(MAX_RESULTS + 1);

  typedef enum logic {
    CMD_STORE   = 1'b0,
    CMD_RELEASE = 1'b1
  } pmst_cmd_e;

  typedef enum logic [2:0] {
    STAT_STORED    = 3'd0,
    STAT_FULL      = 3'd1,
    STAT_SENT      = 3'd2,
    STAT_DISCARDED = 3'd3,
    STAT_NONE      = 3'd4
  } pmst_status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_STORE,
    S_SCAN,
    S_FLUSH
  } pmst_state_e;

  // Input beat
  typedef struct packed {
    pmst_cmd_e   command;
    logic [7:0]  final_addr;
    logic [7:0]  hop_addr;
    logic [7:0]  src;
    logic [7:0]  ttl;
    logic [7:0]  pay_type;
    logic [15:0] payload_ref;
    logic [15:0] payload_len;
    logic [47:0] dest_mac;
    logic [7:0]  iface_index;
  } pmst_in_t;

  // Result beat
  typedef struct packed {
    pmst_status_e status;
    logic [7:0]   out_dest;
    logic [7:0]   out_src;
    logic [7:0]   out_ttl;
    logic [7:0]   out_type;
    logic [15:0]  out_payload_ref;
    logic [15:0]  out_payload_len;
    logic [47:0]  out_mac;
    logic [7:0]   out_iface;
    logic         last;
  } pmst_out_t;

  // One slot of the message memory: header and payload reference
  typedef struct packed {
    logic [7:0]  dest;
    logic [7:0]  hop_addr;
    logic [7:0]  src;
    logic [7:0]  ttl;
    logic [7:0]  pay_type;
    logic [15:0] payload_ref;
    logic [15:0] payload_len;
  } pmst_entry_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic store_step;
    logic scan_step;
    logic flush;
  } pmst_ctrl_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic store_done;
    logic scan_done;
    logic flush_done;
  } pmst_stat_t;

endpackage

`default_nettype wire

### src/pmst_ctrl.sv
// Controller of the pending message slot table.
// Sequences store, release scan and final flush; depends on pmst_pkg.
`default_nettype none

module pmst_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  pmst_pkg::pmst_cmd_e   in_cmd_i,
  output logic                  in_stall_o,
  output pmst_pkg::pmst_ctrl_t  ctrl_o,
  input  pmst_pkg::pmst_stat_t  stat_i
);
  import pmst_pkg::*;

  pmst_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    ctrl_o     = '0;
    in_stall_o = 1'b1;
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          ctrl_o.load = 1'b1;
          state_d     = (in_cmd_i == CMD_RELEASE) ? S_SCAN : S_STORE;
        end
      end
      S_STORE: begin
        ctrl_o.store_step = 1'b1;
        if (stat_i.store_done) begin
          state_d = S_IDLE;
        end
      end
      S_SCAN: begin
        ctrl_o.scan_step = 1'b1;
        if (stat_i.scan_done) begin
          state_d = S_FLUSH;
        end
      end
      S_FLUSH: begin
        ctrl_o.flush = 1'b1;
        if (stat_i.flush_done) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### src/pmst_dp.sv
// Datapath of the pending message slot table: valid bits, slot memory,
// scan pipeline, pending result and output register. Depends on pmst_pkg.
`default_nettype none

module pmst_dp #(
  parameter int unsigned SLOT_COUNT = pmst_pkg::SLOT_COUNT_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  pmst_pkg::pmst_in_t    in_data_i,
  input  pmst_pkg::pmst_ctrl_t  ctrl_i,
  output pmst_pkg::pmst_stat_t  stat_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output pmst_pkg::pmst_out_t   out_data_o
);
  import pmst_pkg::*;

  localparam int unsigned IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned CW = $clog2(SLOT_COUNT + 1);
  localparam logic [CW-1:0] LastIdx = CW'(SLOT_COUNT - 1);
  localparam logic [CW-1:0] EndIdx  = CW'(SLOT_COUNT);
  localparam logic [CNT_W-1:0] MaxCnt = CNT_W'(MAX_RESULTS);

  // Command beat held for the whole command
  pmst_in_t           cmd_q;
  // Scan position and check stage
  logic [CW-1:0]      idx_q, idx_d;
  logic               chk_valid_q, chk_valid_d;
  logic [IW-1:0]      chk_idx_q, chk_idx_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  // Slot state
  logic [SLOT_COUNT-1:0] valid_q, valid_d;
  pmst_entry_t        mem_q [SLOT_COUNT];
  pmst_entry_t        rdata_q;
  // Result held back until it is known whether it is the last one
  logic               pend_valid_q, pend_valid_d;
  pmst_out_t          pend_q, pend_d;
  // Output register
  logic               out_valid_q, out_valid_d;
  pmst_out_t          out_q, out_d;

  logic               out_free;
  logic               slot_free;
  logic               st_finish;
  logic               store_go;
  logic               chk_match;
  logic               hold;
  logic               scan_adv;
  logic               issue;
  logic               take;
  logic               flush_go;
  pmst_entry_t        wentry;
  pmst_out_t          res;

  assign out_free  = !out_valid_q || !out_stall_i;

  // Store: walk up from slot zero until a free slot or the end
  assign slot_free = !valid_q[idx_q[IW-1:0]];
  assign st_finish = slot_free || (idx_q == LastIdx);
  assign store_go  = ctrl_i.store_step && st_finish && out_free;

  // Release: match the slot held in the read register
  assign chk_match = chk_valid_q && valid_q[chk_idx_q] &&
                     (rdata_q.hop_addr == cmd_q.hop_addr) && (cnt_q < MaxCnt);
  assign hold      = chk_match && pend_valid_q && !out_free;
  assign scan_adv  = ctrl_i.scan_step && !hold;
  assign issue     = scan_adv && (idx_q != EndIdx);
  assign take      = scan_adv && chk_match;
  assign flush_go  = ctrl_i.flush && out_free;

  assign stat_o.store_done = store_go;
  assign stat_o.scan_done  = (!chk_valid_q && (idx_q == EndIdx)) || (cnt_q == MaxCnt);
  assign stat_o.flush_done = flush_go;

  // Build the slot entry from the stored command
  always_comb begin
    wentry.dest        = cmd_q.final_addr;
    wentry.hop_addr    = cmd_q.hop_addr;
    wentry.src         = cmd_q.src;
    wentry.ttl         = cmd_q.ttl;
    wentry.pay_type    = cmd_q.pay_type;
    wentry.payload_ref = cmd_q.payload_ref;
    wentry.payload_len = cmd_q.payload_len;
  end

  // Build a release result from the slot just read; empty payloads are dropped
  always_comb begin
    res                 = '0;
    res.out_dest        = rdata_q.dest;
    res.out_src         = rdata_q.src;
    res.out_ttl         = rdata_q.ttl;
    res.out_type        = rdata_q.pay_type;
    res.out_payload_ref = rdata_q.payload_ref;
    res.out_payload_len = rdata_q.payload_len;
    if (rdata_q.payload_len == 16'd0) begin
      res.status = STAT_DISCARDED;
    end else begin
      res.status    = STAT_SENT;
      res.out_mac   = cmd_q.dest_mac;
      res.out_iface = cmd_q.iface_index;
    end
  end

  // Next values of the control state
  always_comb begin
    idx_d        = idx_q;
    chk_valid_d  = chk_valid_q;
    chk_idx_d    = chk_idx_q;
    cnt_d        = cnt_q;
    valid_d      = valid_q;
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_d        = out_q;

    if (ctrl_i.load) begin
      idx_d        = '0;
      chk_valid_d  = 1'b0;
      cnt_d        = '0;
      pend_valid_d = 1'b0;
    end

    // Store: claim the slot or report full, else advance
    if (ctrl_i.store_step) begin
      if (store_go) begin
        out_valid_d = 1'b1;
        out_d       = '0;
        out_d.last  = 1'b1;
        if (slot_free) begin
          valid_d[idx_q[IW-1:0]] = 1'b1;
          out_d.status           = STAT_STORED;
        end else begin
          out_d.status = STAT_FULL;
        end
      end else if (!st_finish) begin
        idx_d = idx_q + CW'(1);
      end
    end

    // Release scan: issue the next read, free a matching slot
    if (scan_adv) begin
      chk_valid_d = issue;
      if (issue) begin
        chk_idx_d = idx_q[IW-1:0];
        idx_d     = idx_q + CW'(1);
      end
      if (take) begin
        valid_d[chk_idx_q] = 1'b0;
        cnt_d              = cnt_q + CNT_W'(1);
        pend_valid_d       = 1'b1;
        pend_d             = res;
        if (pend_valid_q) begin
          out_valid_d = 1'b1;
          out_d       = pend_q;
        end
      end
    end

    // Flush: last result of the release, or none matched
    if (flush_go) begin
      out_valid_d  = 1'b1;
      pend_valid_d = 1'b0;
      if (pend_valid_q) begin
        out_d = pend_q;
      end else begin
        out_d        = '0;
        out_d.status = STAT_NONE;
      end
      out_d.last = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q        <= '0;
      chk_valid_q  <= 1'b0;
      cnt_q        <= '0;
      valid_q      <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      idx_q        <= idx_d;
      chk_valid_q  <= chk_valid_d;
      cnt_q        <= cnt_d;
      valid_q      <= valid_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q <= in_data_i;
    end
    chk_idx_q <= chk_idx_d;
    pend_q    <= pend_d;
    out_q     <= out_d;
  end

  // Slot memory: one write port for stores, one registered read for the scan
  always_ff @(posedge clk_i) begin
    if (store_go && slot_free) begin
      mem_q[idx_q[IW-1:0]] <= wentry;
    end
    if (issue) begin
      rdata_q <= mem_q[idx_q[IW-1:0]];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

### src/pending_message_slot_table.sv
// Top level of the pending message slot table.
// Joins the controller pmst_ctrl and the datapath pmst_dp; depends on pmst_pkg.
//
// Keeps up to SLOT_COUNT message headers that wait for address resolution.
// A store beat goes into the lowest free slot and returns one result,
// stored or table full. A release beat frees every valid slot whose next hop
// matches, in ascending slot order, and returns one result per slot (sent,
// or discarded when the payload length is zero), at most 16 per release;
// the final result has last set, and a release without a match returns a
// single none-matched result. One command is worked on at a time: the input
// stalls once a command is accepted until that command's last result has
// been loaded into the output register. A store and a release each walk the
// table one slot per cycle, the release through the single read port of the
// slot memory, except while an output stall holds the walk; the result cap
// can end a release scan early. Valid marks clear at reset, with no clearing
// pass.
`default_nettype none

module pending_message_slot_table #(
  parameter int unsigned SLOT_COUNT = pmst_pkg::SLOT_COUNT_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  pmst_pkg::pmst_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output pmst_pkg::pmst_out_t out_data_o
);
  import pmst_pkg::*;

  pmst_ctrl_t ctrl;
  pmst_stat_t stat;

  pmst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_cmd_i   (in_data_i.command),
    .in_stall_o (in_stall_o),
    .ctrl_o     (ctrl),
    .stat_i     (stat)
  );

  pmst_dp #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

### src/pmst_checker.sv
// Port-level checks for the pending message slot table.
// Bound to pending_message_slot_table; depends on pmst_pkg.
`default_nettype none

module pmst_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input pmst_pkg::pmst_in_t  in_data_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input pmst_pkg::pmst_out_t out_data_o
);
  import pmst_pkg::*;

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  // Once a command is taken, no other is taken next cycle
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after accepting a command");

  // Store, full and none-matched results stand alone
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == STAT_STORED ||
                    out_data_o.status == STAT_FULL ||
                    out_data_o.status == STAT_NONE) |-> out_data_o.last)
    else $error("single result without last");

  // Discarded messages carry no length and no send target
  a_discard_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == STAT_DISCARDED |->
      out_data_o.out_payload_len == 16'd0 && out_data_o.out_mac == 48'd0 &&
      out_data_o.out_iface == 8'd0)
    else $error("discarded result with payload or send target");

endmodule

bind pending_message_slot_table pmst_checker u_checker (.*);

`default_nettype wire
